[rtl/core/afcm_pkg.sv]
// Package for the box versus frustum plane classifier.
// Holds widths, plane counts and verdict codes; no dependencies.
package afcm_pkg;

  localparam int COORD_BITS  = 16;
  localparam int COEF_BITS   = 16;
  localparam int D_SHIFT     = 14;
  localparam int NUM_PLANES  = 6;
  localparam int PLANE_BITS  = 4 * COEF_BITS;
  localparam int CFG_IDX_W   = 3;

  localparam int PROD_W = COORD_BITS + COEF_BITS;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  localparam logic [1:0] VERDICT_OUTSIDE   = 2'd0;
  localparam logic [1:0] VERDICT_INTERSECT = 2'd1;
  localparam logic [1:0] VERDICT_INSIDE    = 2'd2;

  typedef logic [NUM_PLANES-1:0] plane_mask_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;

endpackage

[rtl/core/aabb_frustum_classify_masked_core.sv]
// Top level of the box versus frustum plane classifier.
// Depends on afcm_pkg for widths and verdict codes.
//
// The block takes one box word per cycle while the output side does not stall
// and raises out_valid with its verdict word, in order, once the box has passed
// four register stages: the six coordinate products of each plane, pairwise sums
// with the scaled plane offset, the eight corner sums with their sign tests, and
// the ordered walk over the six planes that builds the verdict and mask. Stalls
// from the output side back up stage by stage, and a bubble anywhere lets a new
// word in while a finished verdict waits. The user must write planes through the
// configuration port while no box is in flight; the block does not enforce this.
// Indexes above five are ignored.
module aabb_frustum_classify_masked_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  afcm_pkg::coord_t                min_x,
  input  afcm_pkg::coord_t                min_y,
  input  afcm_pkg::coord_t                min_z,
  input  afcm_pkg::coord_t                max_x,
  input  afcm_pkg::coord_t                max_y,
  input  afcm_pkg::coord_t                max_z,
  input  afcm_pkg::plane_mask_t           mask_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      verdict,
  output afcm_pkg::plane_mask_t           mask_out,
  input  logic                            cfg_we,
  input  logic [afcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [afcm_pkg::PLANE_BITS-1:0] cfg_data
);
  import afcm_pkg::*;

  logic [PLANE_BITS-1:0] plane [NUM_PLANES];

  logic s1_valid, s2_valid, s3_valid;
  logic adv1, adv2, adv3, adv4;

  logic signed [PROD_W-1:0] s1_px [NUM_PLANES][2];
  logic signed [PROD_W-1:0] s1_py [NUM_PLANES][2];
  logic signed [PROD_W-1:0] s1_pz [NUM_PLANES][2];
  plane_mask_t              s1_mask;

  logic signed [PAIR_W-1:0] s2_xy [NUM_PLANES][2][2];
  logic signed [PAIR_W-1:0] s2_zd [NUM_PLANES][2];
  plane_mask_t              s2_mask;

  plane_mask_t s3_none, s3_all, s3_mask;

  logic signed [PROD_W-1:0] px_next [NUM_PLANES][2];
  logic signed [PROD_W-1:0] py_next [NUM_PLANES][2];
  logic signed [PROD_W-1:0] pz_next [NUM_PLANES][2];
  logic signed [PAIR_W-1:0] xy_next [NUM_PLANES][2][2];
  logic signed [PAIR_W-1:0] zd_next [NUM_PLANES][2];
  plane_mask_t none_next, all_next;
  logic [1:0]  verdict_next;
  plane_mask_t mask_next;

  assign adv4     = !out_valid || out_ready;
  assign adv3     = !s3_valid || adv4;
  assign adv2     = !s2_valid || adv3;
  assign adv1     = !s1_valid || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        plane[p] <= '0;
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_PLANES))) begin
      plane[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      px_next[p][0] = $signed(plane[p][COEF_BITS-1:0]) * min_x;
      px_next[p][1] = $signed(plane[p][COEF_BITS-1:0]) * max_x;
      py_next[p][0] = $signed(plane[p][2*COEF_BITS-1:COEF_BITS]) * min_y;
      py_next[p][1] = $signed(plane[p][2*COEF_BITS-1:COEF_BITS]) * max_y;
      pz_next[p][0] = $signed(plane[p][3*COEF_BITS-1:2*COEF_BITS]) * min_z;
      pz_next[p][1] = $signed(plane[p][3*COEF_BITS-1:2*COEF_BITS]) * max_z;
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int ky = 0; ky < 2; ky++) begin
        for (int kx = 0; kx < 2; kx++) begin
          xy_next[p][ky][kx] = PAIR_W'(s1_px[p][kx]) + PAIR_W'(s1_py[p][ky]);
        end
      end
      for (int kz = 0; kz < 2; kz++) begin
        zd_next[p][kz] = PAIR_W'(s1_pz[p][kz])
                       + PAIR_W'($signed({plane[p][4*COEF_BITS-1:3*COEF_BITS],
                                          {D_SHIFT{1'b0}}}));
      end
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] s;
    logic                    pos;
    for (int p = 0; p < NUM_PLANES; p++) begin
      none_next[p] = 1'b1;
      all_next[p]  = 1'b1;
      for (int kz = 0; kz < 2; kz++) begin
        for (int ky = 0; ky < 2; ky++) begin
          for (int kx = 0; kx < 2; kx++) begin
            s   = SUM_W'(s2_xy[p][ky][kx]) + SUM_W'(s2_zd[p][kz]);
            pos = !s[SUM_W-1] && (s != '0);
            none_next[p] = none_next[p] && !pos;
            all_next[p]  = all_next[p] && pos;
          end
        end
      end
    end
  end

  always_comb begin
    logic alive;
    logic all_in;
    alive     = 1'b1;
    all_in    = 1'b1;
    mask_next = s3_mask;
    for (int p = 0; p < NUM_PLANES; p++) begin
      if (alive && !s3_mask[p]) begin
        if (s3_none[p]) begin
          alive = 1'b0;
        end else if (s3_all[p]) begin
          mask_next[p] = 1'b1;
        end else begin
          all_in = 1'b0;
        end
      end
    end
    if (!alive) begin
      verdict_next = VERDICT_OUTSIDE;
    end else if (all_in) begin
      verdict_next = VERDICT_INSIDE;
    end else begin
      verdict_next = VERDICT_INTERSECT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid <= in_valid;
      end
      if (adv2) begin
        s2_valid <= s1_valid;
      end
      if (adv3) begin
        s3_valid <= s2_valid;
      end
      if (adv4) begin
        out_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_px   <= px_next;
      s1_py   <= py_next;
      s1_pz   <= pz_next;
      s1_mask <= mask_in;
    end
    if (adv2 && s1_valid) begin
      s2_xy   <= xy_next;
      s2_zd   <= zd_next;
      s2_mask <= s1_mask;
    end
    if (adv3 && s2_valid) begin
      s3_none <= none_next;
      s3_all  <= all_next;
      s3_mask <= s2_mask;
    end
    if (adv4 && s3_valid) begin
      verdict  <= verdict_next;
      mask_out <= mask_next;
    end
  end

endmodule
